### rtl/art_pkg.sv
// Shared types, constants and helpers for the address region table.
`timescale 1ns / 1ps

package art_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_BITS     = 48;

  // Fixed port field widths
  localparam int FIELD_BITS    = 48;
  localparam int SLOT_OUT_BITS = 4;

  localparam int SLOT_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int RANK_BITS = SLOT_BITS;
  localparam int CNT_BITS  = $clog2(TABLE_ENTRIES + 1);

  typedef logic [ADDR_BITS-1:0]     addr_t;
  typedef logic [ADDR_BITS:0]       sum_t;
  typedef logic [FIELD_BITS-1:0]    field_t;
  typedef logic [SLOT_BITS-1:0]     slot_t;
  typedef logic [RANK_BITS-1:0]     rank_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;
  typedef logic [SLOT_OUT_BITS-1:0] slot_out_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  // What the datapath does with each entry read during a walk
  typedef enum logic [1:0] {
    WALK_SEARCH = 2'd0,
    WALK_INC    = 2'd1,
    WALK_DEC    = 2'd2
  } walk_e;

  // Controller to datapath
  typedef struct packed {
    logic  load_query;
    logic  clear;
    logic  rd;
    slot_t addr;
    walk_e mode;
    logic  commit_add;
    logic  commit_remove;
    logic  load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic found;
    logic out_free;
  } dp_flags_t;

  // Port field to internal address (truncate or zero extend)
  function automatic addr_t field_to_addr(input field_t f);
    logic [ADDR_BITS+FIELD_BITS-1:0] ext;
    ext = {{ADDR_BITS{1'b0}}, f};
    return ext[ADDR_BITS-1:0];
  endfunction

  // Internal address to port field (truncate or zero extend)
  function automatic field_t addr_to_field(input addr_t a);
    logic [ADDR_BITS+FIELD_BITS-1:0] ext;
    ext = {{FIELD_BITS{1'b0}}, a};
    return ext[FIELD_BITS-1:0];
  endfunction

  // Slot number to the low bits shown on the port
  function automatic slot_out_t slot_to_out(input slot_t s);
    logic [SLOT_BITS+SLOT_OUT_BITS-1:0] ext;
    ext = {{SLOT_OUT_BITS{1'b0}}, s};
    return ext[SLOT_OUT_BITS-1:0];
  endfunction

endpackage

### rtl/art_dp.sv
// Datapath: entry memories, valid bits, walk stage, best-match tracking, result register.
`timescale 1ns / 1ps

module art_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  art_pkg::cmd_e      command_i,
  input  art_pkg::field_t    area_start_i,
  input  art_pkg::field_t    area_length_i,
  input  art_pkg::dp_cmd_t   cmd_i,
  output art_pkg::dp_flags_t flags_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output art_pkg::field_t    match_start_o,
  output art_pkg::field_t    match_length_o,
  output art_pkg::slot_out_t match_slot_o
);
  import art_pkg::*;

  // Query registers
  cmd_e  cmd_q;
  addr_t qa_q, ql_q;
  sum_t  qend_q;
  logic  full_q;

  // Table state
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  cnt_t                     count_q, count_d;
  addr_t                    start_mem [TABLE_ENTRIES];
  addr_t                    len_mem   [TABLE_ENTRIES];
  rank_t                    rank_mem  [TABLE_ENTRIES];

  // Read stage
  logic  rd_q;
  slot_t addr_q;
  walk_e mode_q;
  addr_t rd_start_q, rd_len_q;
  rank_t rd_rank_q;

  // Walk results
  logic  found_q, free_found_q;
  slot_t best_slot_q, free_slot_q;
  rank_t best_rank_q;
  addr_t best_start_q, best_len_q;

  // Result register
  logic      out_valid_q;
  status_e   out_status_q, res_status;
  field_t    out_start_q, out_len_q, res_start, res_len;
  slot_out_t out_slot_q, res_slot;

  // Walk stage decode
  logic  entry_live, hit_find, hit_exact, hit, take_best, take_free;
  sum_t  entry_end;
  logic  rank_we;
  slot_t rank_waddr;
  rank_t rank_wdata;

  assign flags_o.full     = (count_q == CNT_BITS'(TABLE_ENTRIES));
  assign flags_o.found    = found_q;
  assign flags_o.out_free = !out_valid_q || !out_stall_i;

  // Compare the entry read last cycle against the query
  always_comb begin
    entry_live = rd_q && valid_q[addr_q];
    entry_end  = {1'b0, rd_start_q} + {1'b0, rd_len_q};
    hit_find   = (qa_q >= rd_start_q) && (qend_q <= entry_end);
    hit_exact  = (rd_start_q == qa_q) && (rd_len_q == ql_q);
    hit        = (cmd_q == CMD_FIND) ? hit_find : hit_exact;
    take_best  = entry_live && (mode_q == WALK_SEARCH) && hit &&
                 (!found_q || (rd_rank_q < best_rank_q));
    take_free  = rd_q && (mode_q == WALK_INC) && !valid_q[addr_q] && !free_found_q;
  end

  // Rank updates: age on add, close the gap on remove, newest on commit
  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = addr_q;
    rank_wdata = rd_rank_q;
    if (cmd_i.commit_add) begin
      rank_we    = 1'b1;
      rank_waddr = free_slot_q;
      rank_wdata = '0;
    end else if (entry_live && (mode_q == WALK_INC)) begin
      rank_we    = 1'b1;
      rank_wdata = rd_rank_q + RANK_BITS'(1);
    end else if (entry_live && (mode_q == WALK_DEC) && (rd_rank_q > best_rank_q)) begin
      rank_we    = 1'b1;
      rank_wdata = rd_rank_q - RANK_BITS'(1);
    end
  end

  // Valid bits and fill count
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      valid_d = '0;
      count_d = '0;
    end else if (cmd_i.commit_add) begin
      valid_d[free_slot_q] = 1'b1;
      count_d = count_q + CNT_BITS'(1);
    end else if (cmd_i.commit_remove) begin
      valid_d[best_slot_q] = 1'b0;
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      rd_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      rd_q    <= cmd_i.rd;
    end
  end

  // Entry memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_add) begin
      start_mem[free_slot_q] <= qa_q;
      len_mem[free_slot_q]   <= ql_q;
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    if (cmd_i.rd) begin
      rd_start_q <= start_mem[cmd_i.addr];
      rd_len_q   <= len_mem[cmd_i.addr];
      rd_rank_q  <= rank_mem[cmd_i.addr];
    end
    addr_q <= cmd_i.addr;
    mode_q <= cmd_i.mode;
  end

  // Query capture and walk results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load_query) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (take_best) found_q <= 1'b1;
      if (take_free) free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      cmd_q  <= command_i;
      qa_q   <= field_to_addr(area_start_i);
      ql_q   <= field_to_addr(area_length_i);
      qend_q <= {1'b0, field_to_addr(area_start_i)} + {1'b0, field_to_addr(area_length_i)};
      full_q <= flags_o.full;
    end
    if (take_best) begin
      best_slot_q  <= addr_q;
      best_rank_q  <= rd_rank_q;
      best_start_q <= rd_start_q;
      best_len_q   <= rd_len_q;
    end
    if (take_free) begin
      free_slot_q <= addr_q;
    end
  end

  // Result selection
  always_comb begin
    res_status = STATUS_OK;
    res_start  = '0;
    res_len    = '0;
    res_slot   = '0;
    case (cmd_q)
      CMD_ADD: begin
        if (full_q) begin
          res_status = STATUS_FULL;
        end else begin
          res_slot = slot_to_out(free_slot_q);
        end
      end
      CMD_FIND, CMD_REMOVE: begin
        if (found_q) begin
          res_start = addr_to_field(best_start_q);
          res_len   = addr_to_field(best_len_q);
          res_slot  = slot_to_out(best_slot_q);
        end else begin
          res_status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status;
      out_start_q  <= res_start;
      out_len_q    <= res_len;
      out_slot_q   <= res_slot;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign match_start_o  = out_start_q;
  assign match_length_o = out_len_q;
  assign match_slot_o   = out_slot_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("fill count disagrees with valid bits");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result register loaded while a transaction is stalled");

  a_add_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_add |-> (free_found_q && !valid_q[free_slot_q]))
    else $error("add committed without a free slot");

  a_remove_live_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_remove |-> (found_q && valid_q[best_slot_q]))
    else $error("remove committed on an empty slot");

  a_rank_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rank_we && !cmd_i.commit_add) |-> valid_q[addr_q])
    else $error("rank rewritten on an empty slot");
`endif

endmodule

### rtl/art_ctrl.sv
// Controller: sequences the table walks and result hand-off for each command.
`timescale 1ns / 1ps

module art_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  art_pkg::cmd_e      command_i,
  input  art_pkg::dp_flags_t flags_i,
  output art_pkg::dp_cmd_t   cmd_o
);
  import art_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DECIDE,
    S_DEC_WALK,
    S_DEC_DRAIN,
    S_FINISH
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  slot_t  walk_q;
  logic   walk_last;

  assign walk_last  = (walk_q == SLOT_BITS'(TABLE_ENTRIES - 1));
  assign in_stall_o = (state_q != S_IDLE);

  // Command decode
  always_comb begin
    cmd_o               = '0;
    cmd_o.addr          = walk_q;
    cmd_o.mode          = WALK_SEARCH;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_query = in_valid_i;
        cmd_o.clear      = in_valid_i && (command_i == CMD_CLEAR);
      end
      S_WALK: begin
        cmd_o.rd   = 1'b1;
        cmd_o.mode = (cmd_q == CMD_ADD) ? WALK_INC : WALK_SEARCH;
      end
      S_DRAIN: begin
        cmd_o.mode = (cmd_q == CMD_ADD) ? WALK_INC : WALK_SEARCH;
      end
      S_DECIDE: begin
        cmd_o.commit_add = (cmd_q == CMD_ADD);
      end
      S_DEC_WALK: begin
        cmd_o.rd   = 1'b1;
        cmd_o.mode = WALK_DEC;
      end
      S_DEC_DRAIN: begin
        cmd_o.mode          = WALK_DEC;
        cmd_o.commit_remove = 1'b1;
      end
      S_FINISH: begin
        cmd_o.load_out = flags_i.out_free;
      end
      default: begin
        cmd_o.mode = WALK_SEARCH;
      end
    endcase
  end

  // State, accepted command and walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_ADD;
      walk_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          walk_q <= '0;
          if (in_valid_i) begin
            cmd_q <= command_i;
            if ((command_i == CMD_CLEAR) || ((command_i == CMD_ADD) && flags_i.full)) begin
              state_q <= S_FINISH;
            end else begin
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (walk_last) begin
            walk_q  <= '0;
            state_q <= S_DRAIN;
          end else begin
            walk_q <= walk_q + SLOT_BITS'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if ((cmd_q == CMD_REMOVE) && flags_i.found) begin
            state_q <= S_DEC_WALK;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_DEC_WALK: begin
          if (walk_last) begin
            walk_q  <= '0;
            state_q <= S_DEC_DRAIN;
          end else begin
            walk_q <= walk_q + SLOT_BITS'(1);
          end
        end
        S_DEC_DRAIN: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (flags_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/address_region_table.sv
// Top level of the address region table: controller plus datapath.
//
//   channel  direction  handshake                  payload
//   input    in         in_valid_i / in_stall_o    command_i, area_start_i, area_length_i
//   output   out        out_valid_o / out_stall_i  status_o, match_start_o,
//                                                  match_length_o, match_slot_o
//
// Transaction steps (N = table entries, 16 here): clear and add to a full table go
// straight to the result step; add, find and a remove that misses walk the N entries
// once; a remove that hits walks them again, as the rank fix-up needs a second walk.
// The walks read one entry per cycle from the entry memories.
// Reset clears the valid bits and fill count at once; the table is empty after reset.
// Results wait in an output register; a stalled result holds the block in its last step.
`timescale 1ns / 1ps

module address_region_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [47:0] area_start_i,
  input  logic [47:0] area_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [47:0] match_start_o,
  output logic [47:0] match_length_o,
  output logic [3:0]  match_slot_o
);
  import art_pkg::*;

  dp_cmd_t   dp_cmd;
  dp_flags_t dp_flags;
  cmd_e      command;

  assign command = cmd_e'(command_i);

  art_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command),
    .flags_i    (dp_flags),
    .cmd_o      (dp_cmd)
  );

  art_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (command),
    .area_start_i   (area_start_i),
    .area_length_i  (area_length_i),
    .cmd_i          (dp_cmd),
    .flags_o        (dp_flags),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .match_start_o  (match_start_o),
    .match_length_o (match_length_o),
    .match_slot_o   (match_slot_o)
  );

endmodule
